/* rtl/timer_dma_irq_register_block_macros.svh */
// Assertion macros shared by the timer, DMA and interrupt register block.
`ifndef TIMER_DMA_IRQ_REGISTER_BLOCK_MACROS_SVH
`define TIMER_DMA_IRQ_REGISTER_BLOCK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDIRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TDIRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tdirb_pkg.sv */
// Package with types, register offsets and command codes of the timer, DMA and IRQ block.
`timescale 1ns / 1ps

package tdirb_pkg;

  // Bus command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [15:0] OFF_IRQ_ENABLE      = 16'h0000;
  localparam logic [15:0] OFF_IRQ_SET         = 16'h0004;
  localparam logic [15:0] OFF_IRQ_CLEAR       = 16'h0008;
  localparam logic [15:0] OFF_IRQ_STATUS      = 16'h000c;
  localparam logic [15:0] OFF_TIMER_CONTROL   = 16'h0100;
  localparam logic [15:0] OFF_TIMER_INTERVAL  = 16'h0104;
  localparam logic [15:0] OFF_TIMER_COUNT     = 16'h0108;
  localparam logic [15:0] OFF_DMA_CONTROL     = 16'h0200;
  localparam logic [15:0] OFF_DMA_BASE        = 16'h0204;
  localparam logic [15:0] OFF_DMA_BLOCK_SIZE  = 16'h0208;
  localparam logic [15:0] OFF_DMA_BLOCK_COUNT = 16'h020c;
  localparam logic [15:0] OFF_DMA_BLOCK_INDEX = 16'h0210;
  localparam logic [15:0] OFF_EXT0            = 16'h0300;
  localparam logic [15:0] OFF_EXT1            = 16'h0304;
  localparam logic [15:0] OFF_EXT2            = 16'h0308;
  localparam logic [15:0] OFF_EXT3            = 16'h030c;

  // Control register bit positions.
  localparam int TMR_START_BIT    = 0;
  localparam int TMR_PERIODIC_BIT = 1;
  localparam int TMR_IRQEN_BIT    = 2;
  localparam int TMR_DMAEN_BIT    = 3;
  localparam int DMA_EN_BIT       = 0;
  localparam int DMA_M2P_BIT      = 1;

  // Elapsed time saturates at the top of its 33-bit range.
  localparam logic [32:0] ELAPSED_MAX = 33'h1_FFFF_FFFF;

  // One bus transaction towards the block.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] offset;
    logic [31:0] write_data;
  } in_t;

  // One result transaction from the block.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic        dma_request;
    logic [31:0] dma_address;
    logic [31:0] dma_length;
    logic        dma_to_peripheral;
  } out_t;

endpackage

/* rtl/timer_dma_irq_register_block.sv */
// Timer, block DMA and interrupt register block with registered input and result stages.
`timescale 1ns / 1ps
// An accepted transaction is held in the input register, and its result then in the result register.
// Throughput: one transaction per cycle while the result side does not stall; the input and result registers
// form a two-entry pipeline, so input is stalled only while both are full and held.
// All state updates and the DMA address product are computed combinationally between them.
// Reset (rst, synchronous, active high) clears every state register and both valid flags.

module timer_dma_irq_register_block (
  input  logic            clk,
  input  logic            rst,
  input  logic            bus_valid,
  output logic            bus_stall,
  input  tdirb_pkg::in_t  bus_item,
  output logic            result_valid,
  input  logic            result_stall,
  output tdirb_pkg::out_t result_item
);

  `include "timer_dma_irq_register_block_macros.svh"

  // Input stage.
  logic           a_valid;
  tdirb_pkg::in_t a_item;
  logic           a_go;

  // Architectural registers and their next values.
  logic [31:0] irq_enable, irq_enable_next;
  logic [31:0] irq_status, irq_status_next;
  logic [31:0] timer_control, timer_control_next;
  logic [31:0] timer_interval, timer_interval_next;
  logic [31:0] timer_count, timer_count_next;
  logic [32:0] elapsed_ticks, elapsed_ticks_next;
  logic [31:0] dma_control, dma_control_next;
  logic [31:0] dma_base, dma_base_next;
  logic [31:0] dma_block_size, dma_block_size_next;
  logic [31:0] dma_block_count, dma_block_count_next;
  logic [31:0] dma_block_index, dma_block_index_next;
  logic [31:0] ext_reg [4];
  logic [31:0] ext_reg_next [4];

  // Tick datapath.
  logic [32:0] elapsed_inc;
  logic        tick_fire;
  logic        fire_dma;
  logic [31:0] dma_prod;
  logic [31:0] index_inc;

  tdirb_pkg::out_t res_next;

  // The input stage moves on when the result register is empty or being taken.
  assign a_go      = a_valid && (!result_valid || !result_stall);
  assign bus_stall = a_valid && !a_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (bus_valid && !bus_stall) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bus_valid && !bus_stall) begin
      a_item <= bus_item;
    end
  end

  // Tick arithmetic from the current state.
  assign elapsed_inc = (elapsed_ticks != tdirb_pkg::ELAPSED_MAX) ? elapsed_ticks + 33'd1
                                                                 : elapsed_ticks;
  assign tick_fire   = elapsed_inc > {1'b0, timer_interval};
  assign dma_prod    = dma_block_size * dma_block_index;
  assign index_inc   = dma_block_index + 32'd1;
  assign fire_dma    = (a_item.cmd == tdirb_pkg::CMD_TICK)
                       && timer_control[tdirb_pkg::TMR_START_BIT]
                       && tick_fire && timer_control[tdirb_pkg::TMR_DMAEN_BIT]
                       && dma_control[tdirb_pkg::DMA_EN_BIT];

  // Next state and result for the transaction in the input stage.
  always_comb begin
    irq_enable_next      = irq_enable;
    irq_status_next      = irq_status;
    timer_control_next   = timer_control;
    timer_interval_next  = timer_interval;
    timer_count_next     = timer_count;
    elapsed_ticks_next   = elapsed_ticks;
    dma_control_next     = dma_control;
    dma_base_next        = dma_base;
    dma_block_size_next  = dma_block_size;
    dma_block_count_next = dma_block_count;
    dma_block_index_next = dma_block_index;
    ext_reg_next         = ext_reg;
    res_next             = '0;

    case (a_item.cmd)
      tdirb_pkg::CMD_READ: begin
        case (a_item.offset)
          tdirb_pkg::OFF_IRQ_ENABLE:      res_next.read_data = irq_enable;
          tdirb_pkg::OFF_IRQ_STATUS:      res_next.read_data = irq_status;
          tdirb_pkg::OFF_TIMER_CONTROL:   res_next.read_data = timer_control;
          tdirb_pkg::OFF_TIMER_INTERVAL:  res_next.read_data = timer_interval;
          tdirb_pkg::OFF_TIMER_COUNT:     res_next.read_data = timer_count;
          tdirb_pkg::OFF_DMA_CONTROL:     res_next.read_data = dma_control;
          tdirb_pkg::OFF_DMA_BASE:        res_next.read_data = dma_base;
          tdirb_pkg::OFF_DMA_BLOCK_SIZE:  res_next.read_data = dma_block_size;
          tdirb_pkg::OFF_DMA_BLOCK_COUNT: res_next.read_data = dma_block_count;
          tdirb_pkg::OFF_DMA_BLOCK_INDEX: res_next.read_data = dma_block_index;
          tdirb_pkg::OFF_EXT0:            res_next.read_data = ext_reg[0];
          tdirb_pkg::OFF_EXT1:            res_next.read_data = ext_reg[1];
          tdirb_pkg::OFF_EXT2:            res_next.read_data = ext_reg[2];
          tdirb_pkg::OFF_EXT3:            res_next.read_data = ext_reg[3];
          default:                        res_next.read_data = '0;
        endcase
      end
      tdirb_pkg::CMD_WRITE: begin
        case (a_item.offset)
          tdirb_pkg::OFF_IRQ_ENABLE: irq_enable_next = a_item.write_data;
          tdirb_pkg::OFF_IRQ_SET:    irq_status_next = irq_status | a_item.write_data;
          tdirb_pkg::OFF_IRQ_CLEAR:  irq_status_next = irq_status & ~a_item.write_data;
          tdirb_pkg::OFF_TIMER_CONTROL: begin
            // A rising start bit restarts the elapsed time and the fire count.
            if (a_item.write_data[tdirb_pkg::TMR_START_BIT]
                && !timer_control[tdirb_pkg::TMR_START_BIT]) begin
              elapsed_ticks_next = '0;
              timer_count_next   = '0;
            end
            timer_control_next = a_item.write_data;
          end
          tdirb_pkg::OFF_TIMER_INTERVAL: timer_interval_next = a_item.write_data;
          tdirb_pkg::OFF_DMA_CONTROL: begin
            // A rising enable bit rewinds the block index.
            if (a_item.write_data[tdirb_pkg::DMA_EN_BIT]
                && !dma_control[tdirb_pkg::DMA_EN_BIT]) begin
              dma_block_index_next = '0;
            end
            dma_control_next = a_item.write_data;
          end
          tdirb_pkg::OFF_DMA_BASE:        dma_base_next        = a_item.write_data;
          tdirb_pkg::OFF_DMA_BLOCK_SIZE:  dma_block_size_next  = a_item.write_data;
          tdirb_pkg::OFF_DMA_BLOCK_COUNT: dma_block_count_next = a_item.write_data;
          tdirb_pkg::OFF_EXT0:            ext_reg_next[0]      = a_item.write_data;
          tdirb_pkg::OFF_EXT1:            ext_reg_next[1]      = a_item.write_data;
          tdirb_pkg::OFF_EXT2:            ext_reg_next[2]      = a_item.write_data;
          tdirb_pkg::OFF_EXT3:            ext_reg_next[3]      = a_item.write_data;
          default: ;
        endcase
      end
      tdirb_pkg::CMD_TICK: begin
        // A running timer counts, and fires once elapsed time passes the interval.
        if (timer_control[tdirb_pkg::TMR_START_BIT]) begin
          elapsed_ticks_next = elapsed_inc;
          if (tick_fire) begin
            if (timer_control[tdirb_pkg::TMR_PERIODIC_BIT]) begin
              elapsed_ticks_next = '0;
            end else begin
              timer_control_next[tdirb_pkg::TMR_START_BIT] = 1'b0;
            end
            timer_count_next = timer_count + 32'd1;
            if (fire_dma) begin
              res_next.dma_request       = 1'b1;
              res_next.dma_address       = dma_base + dma_prod;
              res_next.dma_length        = dma_block_size;
              res_next.dma_to_peripheral = dma_control[tdirb_pkg::DMA_M2P_BIT];
              dma_block_index_next = (index_inc >= dma_block_count) ? '0 : index_inc;
            end
            if (timer_control[tdirb_pkg::TMR_IRQEN_BIT]) begin
              irq_status_next = irq_status | 32'd1;
            end
          end
        end
      end
      default: ;
    endcase

    res_next.irq_line = |(irq_enable_next & irq_status_next);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable      <= '0;
      irq_status      <= '0;
      timer_control   <= '0;
      timer_interval  <= '0;
      timer_count     <= '0;
      elapsed_ticks   <= '0;
      dma_control     <= '0;
      dma_base        <= '0;
      dma_block_size  <= '0;
      dma_block_count <= '0;
      dma_block_index <= '0;
      ext_reg         <= '{default: '0};
    end else if (a_go) begin
      irq_enable      <= irq_enable_next;
      irq_status      <= irq_status_next;
      timer_control   <= timer_control_next;
      timer_interval  <= timer_interval_next;
      timer_count     <= timer_count_next;
      elapsed_ticks   <= elapsed_ticks_next;
      dma_control     <= dma_control_next;
      dma_base        <= dma_base_next;
      dma_block_size  <= dma_block_size_next;
      dma_block_count <= dma_block_count_next;
      dma_block_index <= dma_block_index_next;
      ext_reg         <= ext_reg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      result_item <= res_next;
    end
  end

  // Checks on the datapath and the pipeline.
  `TDIRB_ASSERT_NEXT(a_go_gives_result, clk, rst, a_go, result_valid,
    "transaction left the input stage without reaching the result register")
  `TDIRB_ASSERT_NOW(no_dma_fields_idle, clk, rst,
    result_valid && !result_item.dma_request,
    result_item.dma_address == '0 && result_item.dma_length == '0
    && !result_item.dma_to_peripheral,
    "DMA fields set without a DMA request")
  `TDIRB_ASSERT_NEXT(dma_index_wraps, clk, rst, a_go && fire_dma,
    dma_block_index == '0 || dma_block_index < dma_block_count,
    "DMA block index left at or beyond the block count")
  `TDIRB_ASSERT_NEXT(one_shot_stops, clk, rst,
    a_go && (a_item.cmd == tdirb_pkg::CMD_TICK) && timer_control[tdirb_pkg::TMR_START_BIT]
    && tick_fire && !timer_control[tdirb_pkg::TMR_PERIODIC_BIT],
    !timer_control[tdirb_pkg::TMR_START_BIT],
    "one-shot timer still running after it fired")
  `TDIRB_ASSERT_NOW(irq_line_matches, clk, rst, result_valid && $past(a_go),
    result_item.irq_line == (|(irq_enable & irq_status)),
    "interrupt line disagrees with the enable and status registers")

endmodule

/* sim/tb_timer_dma_irq_register_block.sv */
// Self-checking testbench for the timer, block DMA and interrupt register block.
`timescale 1ns / 1ps

module tb_timer_dma_irq_register_block;

  // The fourth command code has no meaning and must change nothing.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned TOTAL_ITEMS = 1050;

  localparam logic [15:0] REG_OFFSETS [16] = '{
    tdirb_pkg::OFF_IRQ_ENABLE, tdirb_pkg::OFF_IRQ_SET, tdirb_pkg::OFF_IRQ_CLEAR,
    tdirb_pkg::OFF_IRQ_STATUS, tdirb_pkg::OFF_TIMER_CONTROL, tdirb_pkg::OFF_TIMER_INTERVAL,
    tdirb_pkg::OFF_TIMER_COUNT, tdirb_pkg::OFF_DMA_CONTROL, tdirb_pkg::OFF_DMA_BASE,
    tdirb_pkg::OFF_DMA_BLOCK_SIZE, tdirb_pkg::OFF_DMA_BLOCK_COUNT,
    tdirb_pkg::OFF_DMA_BLOCK_INDEX, tdirb_pkg::OFF_EXT0, tdirb_pkg::OFF_EXT1,
    tdirb_pkg::OFF_EXT2, tdirb_pkg::OFF_EXT3
  };

  logic clk;
  logic rst = 1'b1;
  logic bus_valid = 1'b0;
  logic bus_stall;
  tdirb_pkg::in_t  bus_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  tdirb_pkg::out_t result_item;

  // Shadow copy of the register state, updated on every accepted bus transaction.
  logic [31:0] irq_en_q = '0;
  logic [31:0] irq_stat_q = '0;
  logic [31:0] tmr_ctrl_q = '0;
  logic [31:0] tmr_interval_q = '0;
  logic [31:0] tmr_fires_q = '0;
  logic [32:0] tmr_elapsed_q = '0;
  logic [31:0] dma_ctrl_q = '0;
  logic [31:0] dma_base_q = '0;
  logic [31:0] dma_size_q = '0;
  logic [31:0] dma_count_q = '0;
  logic [31:0] dma_index_q = '0;
  logic [31:0] ext_regs_q [4] = '{default: '0};

  tdirb_pkg::out_t response_queue [$];
  int unsigned mismatch_count = 0;
  int unsigned n_sent = 0;
  int unsigned hold_request = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;

  timer_dma_irq_register_block dut (
    .clk          (clk),
    .rst          (rst),
    .bus_valid    (bus_valid),
    .bus_stall    (bus_stall),
    .bus_item     (bus_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the response to one bus transaction and advances the shadow state.
  task automatic predict_response(input tdirb_pkg::in_t txn, output tdirb_pkg::out_t resp);
    resp = '0;
    case (txn.cmd)
      tdirb_pkg::CMD_READ: begin
        case (txn.offset)
          tdirb_pkg::OFF_IRQ_ENABLE:      resp.read_data = irq_en_q;
          tdirb_pkg::OFF_IRQ_STATUS:      resp.read_data = irq_stat_q;
          tdirb_pkg::OFF_TIMER_CONTROL:   resp.read_data = tmr_ctrl_q;
          tdirb_pkg::OFF_TIMER_INTERVAL:  resp.read_data = tmr_interval_q;
          tdirb_pkg::OFF_TIMER_COUNT:     resp.read_data = tmr_fires_q;
          tdirb_pkg::OFF_DMA_CONTROL:     resp.read_data = dma_ctrl_q;
          tdirb_pkg::OFF_DMA_BASE:        resp.read_data = dma_base_q;
          tdirb_pkg::OFF_DMA_BLOCK_SIZE:  resp.read_data = dma_size_q;
          tdirb_pkg::OFF_DMA_BLOCK_COUNT: resp.read_data = dma_count_q;
          tdirb_pkg::OFF_DMA_BLOCK_INDEX: resp.read_data = dma_index_q;
          tdirb_pkg::OFF_EXT0:            resp.read_data = ext_regs_q[0];
          tdirb_pkg::OFF_EXT1:            resp.read_data = ext_regs_q[1];
          tdirb_pkg::OFF_EXT2:            resp.read_data = ext_regs_q[2];
          tdirb_pkg::OFF_EXT3:            resp.read_data = ext_regs_q[3];
          default:                        resp.read_data = '0;
        endcase
      end
      tdirb_pkg::CMD_WRITE: begin
        case (txn.offset)
          tdirb_pkg::OFF_IRQ_ENABLE: irq_en_q = txn.write_data;
          tdirb_pkg::OFF_IRQ_SET:    irq_stat_q = irq_stat_q | txn.write_data;
          tdirb_pkg::OFF_IRQ_CLEAR:  irq_stat_q = irq_stat_q & ~txn.write_data;
          tdirb_pkg::OFF_TIMER_CONTROL: begin
            // A rising start bit restarts the elapsed time and the fire count.
            if (txn.write_data[tdirb_pkg::TMR_START_BIT]
                && !tmr_ctrl_q[tdirb_pkg::TMR_START_BIT]) begin
              tmr_elapsed_q = '0;
              tmr_fires_q = '0;
            end
            tmr_ctrl_q = txn.write_data;
          end
          tdirb_pkg::OFF_TIMER_INTERVAL: tmr_interval_q = txn.write_data;
          tdirb_pkg::OFF_DMA_CONTROL: begin
            if (txn.write_data[tdirb_pkg::DMA_EN_BIT]
                && !dma_ctrl_q[tdirb_pkg::DMA_EN_BIT]) begin
              dma_index_q = '0;
            end
            dma_ctrl_q = txn.write_data;
          end
          tdirb_pkg::OFF_DMA_BASE:        dma_base_q = txn.write_data;
          tdirb_pkg::OFF_DMA_BLOCK_SIZE:  dma_size_q = txn.write_data;
          tdirb_pkg::OFF_DMA_BLOCK_COUNT: dma_count_q = txn.write_data;
          tdirb_pkg::OFF_EXT0:            ext_regs_q[0] = txn.write_data;
          tdirb_pkg::OFF_EXT1:            ext_regs_q[1] = txn.write_data;
          tdirb_pkg::OFF_EXT2:            ext_regs_q[2] = txn.write_data;
          tdirb_pkg::OFF_EXT3:            ext_regs_q[3] = txn.write_data;
          default: ;
        endcase
      end
      tdirb_pkg::CMD_TICK: begin
        if (tmr_ctrl_q[tdirb_pkg::TMR_START_BIT]) begin
          if (tmr_elapsed_q < tdirb_pkg::ELAPSED_MAX) begin
            tmr_elapsed_q = tmr_elapsed_q + 33'd1;
          end
          // The timer fires once the elapsed time passes the interval.
          if (tmr_elapsed_q > {1'b0, tmr_interval_q}) begin
            if (tmr_ctrl_q[tdirb_pkg::TMR_PERIODIC_BIT]) begin
              tmr_elapsed_q = '0;
            end else begin
              tmr_ctrl_q[tdirb_pkg::TMR_START_BIT] = 1'b0;
            end
            tmr_fires_q = tmr_fires_q + 32'd1;
            if (tmr_ctrl_q[tdirb_pkg::TMR_DMAEN_BIT] && dma_ctrl_q[tdirb_pkg::DMA_EN_BIT]) begin
              resp.dma_request = 1'b1;
              resp.dma_address = dma_base_q + dma_size_q * dma_index_q;
              resp.dma_length = dma_size_q;
              resp.dma_to_peripheral = dma_ctrl_q[tdirb_pkg::DMA_M2P_BIT];
              dma_index_q = dma_index_q + 32'd1;
              if (dma_index_q >= dma_count_q) begin
                dma_index_q = '0;
              end
            end
            if (tmr_ctrl_q[tdirb_pkg::TMR_IRQEN_BIT]) begin
              irq_stat_q[0] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    resp.irq_line = |(irq_en_q & irq_stat_q);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Predicts each accepted bus transaction and checks each accepted result.
  always @(posedge clk) begin : scoreboard
    tdirb_pkg::out_t predicted;
    tdirb_pkg::out_t wanted;
    if (!rst) begin
      if (bus_valid && !bus_stall) begin
        predict_response(bus_item, predicted);
        response_queue.push_back(predicted);
      end
      if (result_valid && !result_stall) begin
        if (response_queue.size() == 0) begin
          $display("%0t: result with nothing outstanding: expected none, actual %h",
                   $time, result_item);
          mismatch_count++;
        end else begin
          wanted = response_queue.pop_front();
          check_field("read_data", wanted.read_data, result_item.read_data);
          check_field("irq_line", 32'(wanted.irq_line), 32'(result_item.irq_line));
          check_field("dma_request", 32'(wanted.dma_request),
                      32'(result_item.dma_request));
          check_field("dma_address", wanted.dma_address, result_item.dma_address);
          check_field("dma_length", wanted.dma_length, result_item.dma_length);
          check_field("dma_to_peripheral", 32'(wanted.dma_to_peripheral),
                      32'(result_item.dma_to_peripheral));
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : result_receiver
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        result_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      result_stall <= recv_gaps && ($urandom_range(0, 99) < 38);
    end
  end

  // Offers one bus transaction, with an optional random gap first, and waits for it.
  task automatic issue(input logic [1:0] cmd, input logic [15:0] offset,
                       input logic [31:0] data);
    while (send_gaps && ($urandom_range(0, 99) < 38)) begin
      bus_valid <= 1'b0;
      @(posedge clk);
    end
    bus_valid <= 1'b1;
    bus_item <= '{cmd: cmd, offset: offset, write_data: data};
    @(posedge clk);
    while (bus_stall) @(posedge clk);
    n_sent++;
  endtask

  // Builds a read or a write to a mapped register with mostly small data.
  function automatic tdirb_pkg::in_t random_access();
    tdirb_pkg::in_t txn;
    txn.cmd = $urandom_range(0, 1) ? tdirb_pkg::CMD_WRITE : tdirb_pkg::CMD_READ;
    txn.offset = REG_OFFSETS[4'($urandom_range(0, 15))];
    txn.write_data = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 15);
    return txn;
  endfunction

  // Read/write, read-only, write-only and unmapped registers, and the unused command.
  task automatic test_register_map();
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_EXT0, 32'hFFFF_FFFF);
    issue(tdirb_pkg::CMD_READ, tdirb_pkg::OFF_EXT0, 32'h0);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_COUNT, 32'hFFFF_FFFF);
    issue(tdirb_pkg::CMD_READ, tdirb_pkg::OFF_TIMER_COUNT, 32'h0);
    issue(tdirb_pkg::CMD_READ, tdirb_pkg::OFF_IRQ_SET, 32'h0);
    issue(tdirb_pkg::CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    issue(tdirb_pkg::CMD_READ, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_UNUSED, tdirb_pkg::OFF_EXT0, 32'h0);
  endtask

  // Interrupt set, clear and the enable mask on the interrupt line.
  task automatic test_interrupts();
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_IRQ_ENABLE, 32'hFFFF_FFFF);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_IRQ_SET, 32'hFFFF_FFFF);
    issue(tdirb_pkg::CMD_READ, tdirb_pkg::OFF_IRQ_STATUS, 32'h0);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_IRQ_CLEAR, 32'hFFFF_FFFF);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_IRQ_ENABLE, 32'h1);
  endtask

  // Periodic firing with DMA wrap and address overflow, then a one-shot that stops.
  task automatic test_timer_dma();
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_BASE, 32'hFFFF_FFF0);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_BLOCK_SIZE, 32'h10);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_BLOCK_COUNT, 32'd2);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_CONTROL, 32'h3);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_INTERVAL, 32'd0);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_CONTROL, 32'hF);
    repeat (3) issue(tdirb_pkg::CMD_TICK, 16'h0, 32'h0);
    issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_CONTROL, 32'h5);
    repeat (2) issue(tdirb_pkg::CMD_TICK, 16'h0, 32'h0);
    issue(tdirb_pkg::CMD_READ, tdirb_pkg::OFF_DMA_BLOCK_INDEX, 32'h0);
  endtask

  // The result side holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    hold_request = 40;
    repeat (6) issue(tdirb_pkg::CMD_TICK, 16'h0, 32'h0);
    repeat (6) issue(tdirb_pkg::CMD_READ, tdirb_pkg::OFF_TIMER_COUNT, 32'h0);
  endtask

  // Mostly programmed timer runs with random content; some noise on every field.
  task automatic test_random_traffic();
    tdirb_pkg::in_t txn;
    int unsigned pick;
    while (n_sent < TOTAL_ITEMS) begin
      send_gaps = !(n_sent >= 500 && n_sent < 650);
      recv_gaps = send_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // Reprogram the timer and DMA, then start from a stopped timer.
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_CONTROL, 32'h0);
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_INTERVAL, $urandom_range(0, 4));
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_CONTROL, 32'h0);
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_BASE, $urandom);
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_BLOCK_SIZE,
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64));
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_BLOCK_COUNT, $urandom_range(0, 5));
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_DMA_CONTROL,
              ($urandom & 32'hFFFF_FFFC) | $urandom_range(0, 3) | 32'h1);
        issue(tdirb_pkg::CMD_WRITE, tdirb_pkg::OFF_TIMER_CONTROL,
              (($urandom_range(0, 1) ? $urandom : 32'h0) & 32'hFFFF_FFF0)
              | ($urandom_range(0, 7) << 1) | 32'h1);
      end else if (pick < 55) begin
        issue(tdirb_pkg::CMD_TICK, 16'($urandom), $urandom);
      end else if (pick < 93) begin
        txn = random_access();
        issue(txn.cmd, txn.offset, txn.write_data);
      end else begin
        issue(2'($urandom), 16'($urandom), $urandom);
      end
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_interrupts();
    test_timer_dma();
    test_backpressure();
    test_random_traffic();
    bus_valid <= 1'b0;
    @(posedge clk);
    while (response_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, response_queue.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
